// ===== rtl/dws_pkg.sv =====
package dws_pkg;

  localparam int TIME_WIDTH_DEF = 32;
  localparam int SUM_WIDTH_DEF  = 48;
  localparam int TS_WIDTH       = 32;
  localparam int OUT_WIDTH      = 32;
  localparam int COUNT_WIDTH    = 32;
  localparam int QUEUE_DEPTH    = 2;

  typedef enum logic [1:0] {
    OP_START       = 2'd0,
    OP_FINISH      = 2'd1,
    OP_CLOSE_SHORT = 2'd2,
    OP_CLOSE_LONG  = 2'd3
  } op_t;

  localparam logic WIN_SHORT = 1'b0;
  localparam logic WIN_LONG  = 1'b1;

  typedef struct packed {
    logic                mark;
    logic                finish;
    logic                close;
    logic                win;
    logic [TS_WIDTH-1:0] ts;
  } item_t;

  typedef enum logic {
    BK_IDLE,
    BK_DIV
  } back_state_t;

endpackage

// ===== rtl/dws_front.sv =====
module dws_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_opcode,
  input  logic [dws_pkg::TS_WIDTH-1:0]   in_timestamp,
  output logic                           q_valid,
  output dws_pkg::item_t                 q_item,
  input  logic                           q_pop
);

  localparam int DEPTH = dws_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(DEPTH + 1);
  localparam logic [PW-1:0]   LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CNTW-1:0] FULL_CNT = CNTW'(DEPTH);

  dws_pkg::item_t        queue_r [DEPTH];
  logic [PW-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]       cnt_r, cnt_nxt;
  dws_pkg::item_t        dec_item;
  logic                  push;
  logic                  pop;

  always_comb begin
    dec_item        = '0;
    dec_item.ts     = in_timestamp;
    unique case (dws_pkg::op_t'(in_opcode))
      dws_pkg::OP_START: begin
        dec_item.mark = 1'b1;
      end
      dws_pkg::OP_FINISH: begin
        dec_item.finish = 1'b1;
      end
      dws_pkg::OP_CLOSE_SHORT: begin
        dec_item.close = 1'b1;
        dec_item.win   = dws_pkg::WIN_SHORT;
      end
      dws_pkg::OP_CLOSE_LONG: begin
        dec_item.close = 1'b1;
        dec_item.win   = dws_pkg::WIN_LONG;
      end
      default: begin
        dec_item.mark = 1'b1;
      end
    endcase
  end

  assign in_ready = (cnt_r != FULL_CNT);
  assign q_valid  = (cnt_r != '0);
  assign q_item   = queue_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= dec_item;
    end
  end

endmodule

// ===== rtl/dws_div.sv =====
module dws_div #(
  parameter int SUM_WIDTH = dws_pkg::SUM_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [SUM_WIDTH-1:0]            dividend,
  input  logic [dws_pkg::COUNT_WIDTH-1:0] divisor,
  output logic                            done,
  output logic [SUM_WIDTH-1:0]            quotient
);

  localparam int CW   = dws_pkg::COUNT_WIDTH;
  localparam int CNTW = $clog2(SUM_WIDTH + 1);

  logic [SUM_WIDTH-1:0] quo_r, quo_nxt;
  logic [CW-1:0]        rem_r, rem_nxt;
  logic [CW-1:0]        dvs_r;
  logic [CNTW-1:0]      cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;
  logic [CW:0]          trial;
  logic [CW:0]          diff;
  logic                 ge;

  assign trial = {rem_r, quo_r[SUM_WIDTH-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = CNTW'(SUM_WIDTH);
    end else if (cnt_r != '0) begin
      quo_nxt  = {quo_r[SUM_WIDTH-2:0], ge};
      rem_nxt  = ge ? diff[CW-1:0] : trial[CW-1:0];
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNTW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/dws_back.sv =====
module dws_back #(
  parameter int TIME_WIDTH = dws_pkg::TIME_WIDTH_DEF,
  parameter int SUM_WIDTH  = dws_pkg::SUM_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  dws_pkg::item_t                q_item,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dws_pkg::OUT_WIDTH-1:0] out_last_duration,
  output logic [dws_pkg::OUT_WIDTH-1:0] out_short_min,
  output logic [dws_pkg::OUT_WIDTH-1:0] out_short_avg,
  output logic [dws_pkg::OUT_WIDTH-1:0] out_short_max,
  output logic [dws_pkg::OUT_WIDTH-1:0] out_long_min,
  output logic [dws_pkg::OUT_WIDTH-1:0] out_long_avg,
  output logic [dws_pkg::OUT_WIDTH-1:0] out_long_max,
  output logic [dws_pkg::OUT_WIDTH-1:0] out_all_min,
  output logic [dws_pkg::OUT_WIDTH-1:0] out_all_max
);

  localparam int TW = TIME_WIDTH;
  localparam int SW = SUM_WIDTH;
  localparam int OW = dws_pkg::OUT_WIDTH;
  localparam int CW = dws_pkg::COUNT_WIDTH;
  localparam int AW = ((TW > SW) ? TW : SW) + 1;
  localparam logic [TW+OW-1:0] TMASK_W = {{OW{1'b0}}, {TW{1'b1}}};
  localparam logic [OW-1:0]    TMASK_O = TMASK_W[OW-1:0];

  dws_pkg::back_state_t state_r, state_nxt;

  logic [TW-1:0] mark_r;
  logic [OW-1:0] last_r;
  logic [TW-1:0] win_min_r   [2];
  logic [TW-1:0] win_max_r   [2];
  logic [SW-1:0] win_sum_r   [2];
  logic [CW-1:0] win_count_r [2];
  logic [OW-1:0] pub_min_r   [2];
  logic [OW-1:0] pub_avg_r   [2];
  logic [OW-1:0] pub_max_r   [2];
  logic [TW-1:0] total_min_r;
  logic [TW-1:0] total_max_r;
  logic          close_w_r;
  logic          out_valid_r, out_valid_nxt;

  logic             take;
  logic             cnt_nz;
  logic             do_mark;
  logic             do_finish;
  logic             do_empty;
  logic             div_start;
  logic             div_done;
  logic [SW-1:0]    quotient;
  logic [TW+OW-1:0] ts_wide;
  logic [TW-1:0]    ts_w;
  logic [TW-1:0]    dur;
  logic [TW+OW-1:0] dur_wide;
  logic [SW-1:0]    sum_upd [2];
  logic [CW-1:0]    cnt_upd [2];
  logic [AW+SW-1:0] sum_ext [2];
  logic [AW+TW-1:0] dur_ext;
  logic [AW-1:0]    sum_add [2];
  logic [TW+OW-1:0] cmin_wide;
  logic [TW+OW-1:0] cmax_wide;
  logic [TW+OW-1:0] tmin_wide;
  logic [TW+OW-1:0] tmax_wide;
  logic [OW-1:0]    avg_o;

  assign ts_wide  = {{TW{1'b0}}, q_item.ts};
  assign ts_w     = ts_wide[TW-1:0];
  assign dur      = ts_w - mark_r;
  assign dur_wide = {{OW{1'b0}}, dur};
  assign dur_ext  = {{AW{1'b0}}, dur};
  assign cnt_nz   = (win_count_r[q_item.win] != '0);

  always_comb begin
    for (int w = 0; w < 2; w++) begin
      sum_ext[w] = {{AW{1'b0}}, win_sum_r[w]};
      sum_add[w] = sum_ext[w][AW-1:0] + dur_ext[AW-1:0];
      sum_upd[w] = (sum_add[w][AW-1:SW] != '0) ? {SW{1'b1}} : sum_add[w][SW-1:0];
      cnt_upd[w] = (win_count_r[w] == {CW{1'b1}}) ? win_count_r[w]
                                                   : win_count_r[w] + 1'b1;
    end
  end

  assign cmin_wide = {{OW{1'b0}}, win_min_r[close_w_r]};
  assign cmax_wide = {{OW{1'b0}}, win_max_r[close_w_r]};
  assign tmin_wide = {{OW{1'b0}}, total_min_r};
  assign tmax_wide = {{OW{1'b0}}, total_max_r};
  assign avg_o     = quotient[OW-1:0] & TMASK_O;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dws_pkg::BK_IDLE: begin
        if (take && q_item.close && cnt_nz) begin
          state_nxt = dws_pkg::BK_DIV;
        end
      end
      dws_pkg::BK_DIV: begin
        if (div_done) begin
          state_nxt = dws_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = dws_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    take      = 1'b0;
    do_mark   = 1'b0;
    do_finish = 1'b0;
    do_empty  = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      dws_pkg::BK_IDLE: begin
        take      = q_valid && (!out_valid_r || out_ready);
        do_mark   = take && q_item.mark;
        do_finish = take && q_item.finish;
        do_empty  = take && q_item.close && !cnt_nz;
        div_start = take && q_item.close && cnt_nz;
      end
      dws_pkg::BK_DIV: begin
      end
      default: begin
      end
    endcase
  end

  assign q_pop = take;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (do_mark || do_finish || do_empty || div_done) begin
      out_valid_nxt = 1'b1;
    end
  end

  dws_div #(
    .SUM_WIDTH (SW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (win_sum_r[q_item.win]),
    .divisor  (win_count_r[q_item.win]),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dws_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
      mark_r      <= '0;
      last_r      <= '0;
      total_min_r <= '1;
      total_max_r <= '0;
      close_w_r   <= dws_pkg::WIN_SHORT;
      for (int w = 0; w < 2; w++) begin
        win_min_r[w]   <= '1;
        win_max_r[w]   <= '0;
        win_sum_r[w]   <= '0;
        win_count_r[w] <= '0;
        pub_min_r[w]   <= '0;
        pub_avg_r[w]   <= '0;
        pub_max_r[w]   <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (do_mark) begin
        mark_r <= ts_w;
      end
      if (do_finish) begin
        mark_r <= ts_w;
        last_r <= dur_wide[OW-1:0];
        if (dur < total_min_r) begin
          total_min_r <= dur;
        end
        if (dur > total_max_r) begin
          total_max_r <= dur;
        end
        for (int w = 0; w < 2; w++) begin
          if (dur < win_min_r[w]) begin
            win_min_r[w] <= dur;
          end
          if (dur > win_max_r[w]) begin
            win_max_r[w] <= dur;
          end
          win_sum_r[w]   <= sum_upd[w];
          win_count_r[w] <= cnt_upd[w];
        end
      end
      if (div_start) begin
        close_w_r <= q_item.win;
      end
      if (do_empty) begin
        pub_min_r[q_item.win]   <= '0;
        pub_avg_r[q_item.win]   <= '0;
        pub_max_r[q_item.win]   <= '0;
        win_min_r[q_item.win]   <= '1;
        win_max_r[q_item.win]   <= '0;
        win_sum_r[q_item.win]   <= '0;
        win_count_r[q_item.win] <= '0;
      end
      if (div_done) begin
        pub_min_r[close_w_r]   <= cmin_wide[OW-1:0];
        pub_avg_r[close_w_r]   <= avg_o;
        pub_max_r[close_w_r]   <= cmax_wide[OW-1:0];
        win_min_r[close_w_r]   <= '1;
        win_max_r[close_w_r]   <= '0;
        win_sum_r[close_w_r]   <= '0;
        win_count_r[close_w_r] <= '0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_last_duration = last_r;
  assign out_short_min     = pub_min_r[dws_pkg::WIN_SHORT];
  assign out_short_avg     = pub_avg_r[dws_pkg::WIN_SHORT];
  assign out_short_max     = pub_max_r[dws_pkg::WIN_SHORT];
  assign out_long_min      = pub_min_r[dws_pkg::WIN_LONG];
  assign out_long_avg      = pub_avg_r[dws_pkg::WIN_LONG];
  assign out_long_max      = pub_max_r[dws_pkg::WIN_LONG];
  assign out_all_min       = tmin_wide[OW-1:0];
  assign out_all_max       = tmax_wide[OW-1:0];

endmodule

// ===== rtl/duration_window_statistics_core.sv =====
// Start and finish items pass through the input queue to the registered result output.
// Closing a non-empty window runs the bit-serial divider that forms the average and
// retires one quotient bit per cycle; an empty close completes like a finish item.
// One start or finish item per cycle with out_ready high; none is taken while dividing.
// Reset (rst_n low, synchronous) clears the input queue, the result and all statistics.
module duration_window_statistics_core #(
  parameter int TIME_WIDTH = dws_pkg::TIME_WIDTH_DEF,
  parameter int SUM_WIDTH  = dws_pkg::SUM_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_opcode,
  input  logic [dws_pkg::TS_WIDTH-1:0]  in_timestamp,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dws_pkg::OUT_WIDTH-1:0] out_last_duration,
  output logic [dws_pkg::OUT_WIDTH-1:0] out_short_min,
  output logic [dws_pkg::OUT_WIDTH-1:0] out_short_avg,
  output logic [dws_pkg::OUT_WIDTH-1:0] out_short_max,
  output logic [dws_pkg::OUT_WIDTH-1:0] out_long_min,
  output logic [dws_pkg::OUT_WIDTH-1:0] out_long_avg,
  output logic [dws_pkg::OUT_WIDTH-1:0] out_long_max,
  output logic [dws_pkg::OUT_WIDTH-1:0] out_all_min,
  output logic [dws_pkg::OUT_WIDTH-1:0] out_all_max
);

  logic           q_valid;
  logic           q_pop;
  dws_pkg::item_t q_item;

  dws_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_timestamp (in_timestamp),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  dws_back #(
    .TIME_WIDTH (TIME_WIDTH),
    .SUM_WIDTH  (SUM_WIDTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_last_duration (out_last_duration),
    .out_short_min     (out_short_min),
    .out_short_avg     (out_short_avg),
    .out_short_max     (out_short_max),
    .out_long_min      (out_long_min),
    .out_long_avg      (out_long_avg),
    .out_long_max      (out_long_max),
    .out_all_min       (out_all_min),
    .out_all_max       (out_all_max)
  );

endmodule
